[rtl/core/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the three-axis linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

	localparam int TIME_W    = 48;
	localparam int VAL_W     = 32;
	localparam int PERIOD_W  = 20;
	localparam int FRAC_BITS = 16;
	localparam int MAX_RUN   = 16;
	localparam int N_AXES    = 3;

	localparam int RUN_W     = $clog2(MAX_RUN + 1);
	localparam int DIV_CNT_W = $clog2(FRAC_BITS);
	localparam int DIFF_W    = VAL_W + 1;
	localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;

	// command queue between front and back
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);

	localparam logic REQ_SAMPLE  = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic                    req_type;
		logic [TIME_W-1:0]       sample_time;
		val_t [N_AXES-1:0]       axis;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0]       out_time;
		val_t [N_AXES-1:0]       axis;
		logic                    last_of_run;
		logic                    more_pending;
	} res_t;

endpackage

[rtl/core/lir_front.sv]
// ----------------------------------------------------------------------------
// lir_front
// Accepts input words and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module lir_front import lir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cmd_t cmd_in,
	output logic q_valid,
	input  logic q_pop,
	output cmd_t q_cmd
);

	cmd_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;
	assign q_cmd    = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

[rtl/core/lir_div.sv]
// ----------------------------------------------------------------------------
// lir_div
// Restoring divider for the interpolation fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lir_div import lir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 zero,
	input  logic [TIME_W-1:0]    num,
	input  logic [TIME_W-1:0]    den,
	output logic                 done,
	output logic [FRAC_BITS-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [TIME_W:0]      shifted;
	logic [TIME_W:0]      diff;
	logic                 ge;

	// remainder stays below the divisor, so the shifted value fits TIME_W+1 bits
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	assign done = done_q;
	assign quot = zero_q ? '0 : quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(FRAC_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			zero_q <= zero;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], ge};
		end
	end

endmodule

[rtl/core/lir_back.sv]
// ----------------------------------------------------------------------------
// lir_back
// Sample history, output schedule, blend datapath and result register.
// ----------------------------------------------------------------------------
module lir_back import lir_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PERIOD_W-1:0] output_period,
	input  logic                q_valid,
	output logic                q_pop,
	input  cmd_t                q_cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output res_t                res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_BLEND = 3'd4;

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	logic [2:0]                state_q;
	logic [TIME_W-1:0]         older_time_q;
	logic                      older_valid_q;
	val_t                      older_val_q [N_AXES];
	logic [TIME_W-1:0]         newer_time_q;
	logic                      newer_valid_q;
	val_t                      newer_val_q [N_AXES];
	logic [TIME_W-1:0]         sched_time_q;
	logic                      sched_valid_q;
	logic [RUN_W-1:0]          run_cnt_q;
	logic                      pend_q;
	logic [TIME_W-1:0]         pend_time_q;
	val_t                      pend_val_q [N_AXES];
	logic signed [DIFF_W-1:0]  diff_q [N_AXES];
	logic signed [PROD_W-1:0]  prod_s1 [N_AXES];
	logic                      out_valid_q;
	res_t                      out_res_q;

	logic [TIME_W:0]           sched_sum;
	logic                      due;
	logic                      cont;
	logic                      out_free;
	logic                      emit_ok;
	logic                      out_load;
	logic [TIME_W-1:0]         t3;
	logic                      div_start;
	logic                      div_zero;
	logic                      div_done;
	logic [TIME_W-1:0]         div_num;
	logic [TIME_W-1:0]         div_den;
	logic [FRAC_BITS-1:0]      frac;
	logic signed [DIFF_W-1:0]  diff_c [N_AXES];
	val_t                      blend_c [N_AXES];

	assign sched_sum = {1'b0, sched_time_q} + (TIME_W + 1)'(output_period);
	assign due       = older_valid_q && newer_valid_q && (sched_sum < {1'b0, newer_time_q});
	assign cont      = due && (run_cnt_q != RUN_W'(MAX_RUN));
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_ok   = !pend_q || out_free;
	assign out_load  = (state_q == ST_CHECK) && emit_ok && pend_q;

	assign t3        = (sched_time_q < older_time_q) ? older_time_q : sched_time_q;
	assign div_num   = t3 - older_time_q;
	assign div_den   = newer_time_q - older_time_q;
	assign div_zero  = (newer_time_q <= older_time_q);
	assign div_start = (state_q == ST_CHECK) && emit_ok && cont;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign res       = out_res_q;

	always_comb begin
		logic signed [PROD_W-1:0] rnd;
		logic signed [PROD_W-1:0] shr;
		for (int i = 0; i < N_AXES; i++) begin
			diff_c[i] = DIFF_W'(newer_val_q[i]) - DIFF_W'(older_val_q[i]);
		end
		for (int i = 0; i < N_AXES; i++) begin
			// round to nearest, ties up; the result stays between the two samples
			rnd        = prod_s1[i] + HALF;
			shr        = rnd >>> FRAC_BITS;
			blend_c[i] = older_val_q[i] + val_t'(shr[VAL_W-1:0]);
		end
	end

	lir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.zero   (div_zero),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (frac)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			older_time_q  <= '0;
			older_valid_q <= 1'b0;
			newer_time_q  <= '0;
			newer_valid_q <= 1'b0;
			sched_time_q  <= '0;
			sched_valid_q <= 1'b0;
			run_cnt_q     <= '0;
			pend_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < N_AXES; i++) begin
				older_val_q[i] <= '0;
				newer_val_q[i] <= '0;
			end
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_cmd.req_type == REQ_RESTART) begin
							older_time_q  <= '0;
							older_valid_q <= 1'b0;
							newer_time_q  <= '0;
							newer_valid_q <= 1'b0;
							sched_time_q  <= '0;
							sched_valid_q <= 1'b0;
							for (int i = 0; i < N_AXES; i++) begin
								older_val_q[i] <= '0;
								newer_val_q[i] <= '0;
							end
						end else begin
							if (!sched_valid_q) begin
								sched_time_q  <= q_cmd.sample_time;
								sched_valid_q <= 1'b1;
							end
							older_time_q  <= newer_time_q;
							older_valid_q <= newer_valid_q;
							newer_time_q  <= q_cmd.sample_time;
							newer_valid_q <= 1'b1;
							for (int i = 0; i < N_AXES; i++) begin
								older_val_q[i] <= newer_val_q[i];
								newer_val_q[i] <= q_cmd.axis[i];
							end
							run_cnt_q <= '0;
							state_q   <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// the held result goes out once we know whether another follows
					if (emit_ok) begin
						if (pend_q) begin
							pend_q <= 1'b0;
						end
						if (cont) begin
							sched_time_q <= sched_sum[TIME_W-1:0];
							run_cnt_q    <= run_cnt_q + 1'b1;
							state_q      <= ST_DIV;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					pend_q  <= 1'b1;
					state_q <= ST_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			pend_time_q <= sched_time_q;
		end
		if (state_q == ST_DIV) begin
			for (int i = 0; i < N_AXES; i++) begin
				diff_q[i] <= diff_c[i];
			end
		end
		if (state_q == ST_MUL) begin
			for (int i = 0; i < N_AXES; i++) begin
				prod_s1[i] <= PROD_W'(diff_q[i]) * PROD_W'($signed({1'b0, frac}));
			end
		end
		if (state_q == ST_BLEND) begin
			for (int i = 0; i < N_AXES; i++) begin
				pend_val_q[i] <= blend_c[i];
			end
		end
		if (out_load) begin
			out_res_q.out_time     <= pend_time_q;
			for (int i = 0; i < N_AXES; i++) begin
				out_res_q.axis[i] <= pend_val_q[i];
			end
			out_res_q.last_of_run  <= !cont;
			out_res_q.more_pending <= !cont && due;
		end
	end

endmodule

[rtl/core/linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Resamples timestamped three-axis samples onto a fixed output period.
// ----------------------------------------------------------------------------
// Input words enter a two-word queue, so the input side keeps accepting
// words while results are computed until the queue is full. A restart word
// is handled in the idle state, and a sample that causes no output passes
// through the schedule check and returns to idle. Each output goes through
// a schedule check, the shared restoring divider that forms the Q0.16
// fraction, a multiply and a round-and-add. A sample emits at most MAX_RUN
// (16) outputs; output stalls can hold the back end in the schedule check.
// The period register may only be written while the block is idle.
module linear_interp_resampler import lir_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [PERIOD_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [TIME_W-1:0]   sample_time,
	input  logic signed [VAL_W-1:0] axis_x_in,
	input  logic signed [VAL_W-1:0] axis_y_in,
	input  logic signed [VAL_W-1:0] axis_z_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TIME_W-1:0]   out_time,
	output logic signed [VAL_W-1:0] axis_x_out,
	output logic signed [VAL_W-1:0] axis_y_out,
	output logic signed [VAL_W-1:0] axis_z_out,
	output logic                last_of_run,
	output logic                more_pending
);

	logic [PERIOD_W-1:0] output_period_q;
	cmd_t                cmd_in;
	cmd_t                q_cmd;
	logic                q_valid;
	logic                q_pop;
	res_t                res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_period_q <= PERIOD_RESET;
		end else if (cfg_wr_en) begin
			output_period_q <= cfg_wr_data;
		end
	end

	assign cmd_in.req_type    = req_type;
	assign cmd_in.sample_time = sample_time;
	assign cmd_in.axis[0]     = axis_x_in;
	assign cmd_in.axis[1]     = axis_y_in;
	assign cmd_in.axis[2]     = axis_z_in;

	lir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd_in   (cmd_in),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd)
	);

	lir_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.output_period (output_period_q),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_cmd         (q_cmd),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.res           (res)
	);

	assign out_time     = res.out_time;
	assign axis_x_out   = res.axis[0];
	assign axis_y_out   = res.axis[1];
	assign axis_z_out   = res.axis[2];
	assign last_of_run  = res.last_of_run;
	assign more_pending = res.more_pending;

endmodule
